// File: src/slt_pkg.sv
package slt_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } slt_op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } slt_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } slt_state_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                     compare;
    logic                     commit;
    logic                     ins_ok;
    slt_op_t                  op;
    logic signed [KEY_W-1:0]  key;
  } slt_ctrl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                     valid;
    logic                     lt;
    logic                     eq;
    logic signed [KEY_W-1:0]  key;
  } slt_link_t;

endpackage

// File: src/slt_if.sv
interface slt_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            req_type;
  logic signed [slt_pkg::KEY_W-1:0]      key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface slt_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [1:0] status;
  logic [4:0] entry_count;

  modport source (output valid, output found, output status, output entry_count, input ready);
  modport sink   (input valid, input found, input status, input entry_count, output ready);
endinterface

// File: src/slt_cell.sv
module slt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  slt_pkg::slt_ctrl_t ctrl,
  input  slt_pkg::slt_link_t left,
  input  slt_pkg::slt_link_t right,
  output slt_pkg::slt_link_t self,
  output logic               first_eq
);

  logic signed [slt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                             valid_r, valid_nxt;
  logic                             lt_r, eq_r;
  logic                             do_shift;

  assign self.valid = valid_r;
  assign self.lt    = lt_r;
  assign self.eq    = eq_r;
  assign self.key   = key_r;

  // Keys are sorted, so equal keys sit together: the first one has no equal on its left.
  assign first_eq = eq_r && !left.eq;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    do_shift  = 1'b0;
    case (ctrl.op)
      slt_pkg::OP_INSERT: begin
        if (ctrl.ins_ok && !lt_r) begin
          if (left.lt) begin
            key_nxt   = ctrl.key;
            valid_nxt = 1'b1;
          end else begin
            key_nxt   = left.key;
            valid_nxt = left.valid;
          end
        end
      end
      slt_pkg::OP_DELETE: begin
        // ins_ok carries the global hit flag for a delete
        do_shift = ctrl.ins_ok && valid_r && !lt_r;
        if (do_shift) begin
          key_nxt   = right.key;
          valid_nxt = right.valid;
        end
      end
      default: begin
        key_nxt   = key_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      if (ctrl.compare) begin
        lt_r <= valid_r && (key_r < ctrl.key);
        eq_r <= valid_r && (key_r == ctrl.key);
      end
      if (ctrl.commit) begin
        valid_r <= valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      key_r <= key_nxt;
    end
  end

endmodule

// File: src/sorted_list_table.sv
// Sorted key table built as a row of cells, one stored key per cell.
// in_ch takes one request (req_type, key): insert, search or delete.
// out_ch gives one result per request: found, status and entry_count,
// the number of stored keys after the request (low 5 bits).
// An item is taken at a clock edge with valid and ready both high.
// A request is compared in every cell at once at the edge that takes it
// (the compare pass); the cell row makes its shift pass at the commit
// edge, and the result is valid after that edge.
// Insert shifts the keys at or above the new key one cell right, delete
// shifts the keys after the first match one cell left; a full table drops the insert.
// If the receiver stalls, the result is held and the pending request
// waits in the commit step; a new request is accepted once it commits.
// Synchronous active-low reset empties the table and drops any result.
module sorted_list_table (
  input  logic             clk,
  input  logic             rst_n,
  slt_in_if.sink           in_ch,
  slt_out_if.source        out_ch
);

  localparam int LAST = slt_pkg::DEPTH - 1;

  slt_pkg::slt_state_t               state_r, state_nxt;
  slt_pkg::slt_op_t                  op_r;
  logic signed [slt_pkg::KEY_W-1:0]  key_r;
  logic [slt_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                              out_valid_r;
  logic                              found_r, found_nxt;
  slt_pkg::slt_status_t              status_r, status_nxt;
  logic [4:0]                        entry_r;
  logic [31:0]                       count_ext;

  logic                              in_fire, commit, full, hit;
  slt_pkg::slt_ctrl_t                ctrl;
  slt_pkg::slt_link_t                link [slt_pkg::DEPTH];
  slt_pkg::slt_link_t                lnk_l [slt_pkg::DEPTH];
  slt_pkg::slt_link_t                lnk_r [slt_pkg::DEPTH];
  logic [slt_pkg::DEPTH-1:0]         first_eq;

  assign in_ch.ready = (state_r == slt_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == slt_pkg::S_EXEC) && (!out_valid_r || out_ch.ready);
  assign full        = (count_r == slt_pkg::CNT_W'(slt_pkg::DEPTH));
  assign hit         = |first_eq;

  always_comb begin
    ctrl.compare = in_fire;
    ctrl.commit  = commit;
    ctrl.op      = in_fire ? slt_pkg::slt_op_t'(in_ch.req_type) : op_r;
    ctrl.key     = in_fire ? in_ch.key : key_r;
    ctrl.ins_ok  = (op_r == slt_pkg::OP_DELETE) ? hit : !full;
    if (!commit) begin
      ctrl.op = slt_pkg::OP_NONE;
    end
  end

  genvar g;
  generate
    for (g = 0; g < slt_pkg::DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign lnk_l[g] = '{valid: 1'b1, lt: 1'b1, eq: 1'b0, key: '0};
      end else begin : g_mid_l
        assign lnk_l[g] = link[g-1];
      end
      if (g == LAST) begin : g_last
        assign lnk_r[g] = '{valid: 1'b0, lt: 1'b0, eq: 1'b0, key: '0};
      end else begin : g_mid_r
        assign lnk_r[g] = link[g+1];
      end
      slt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .left     (lnk_l[g]),
        .right    (lnk_r[g]),
        .self     (link[g]),
        .first_eq (first_eq[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    found_nxt  = 1'b0;
    status_nxt = slt_pkg::ST_DONE;
    case (state_r)
      slt_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = slt_pkg::S_EXEC;
        end
      end
      slt_pkg::S_EXEC: begin
        if (commit) begin
          state_nxt = slt_pkg::S_IDLE;
        end
      end
      default: state_nxt = slt_pkg::S_IDLE;
    endcase
    case (op_r)
      slt_pkg::OP_INSERT: begin
        if (full) begin
          status_nxt = slt_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      slt_pkg::OP_SEARCH: begin
        found_nxt  = hit;
        status_nxt = hit ? slt_pkg::ST_DONE : slt_pkg::ST_ABSENT;
      end
      slt_pkg::OP_DELETE: begin
        found_nxt  = hit;
        status_nxt = hit ? slt_pkg::ST_DONE : slt_pkg::ST_ABSENT;
        if (hit) begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        found_nxt  = 1'b0;
        status_nxt = slt_pkg::ST_DONE;
      end
    endcase
  end

  assign count_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= slt_pkg::slt_op_t'(in_ch.req_type);
      key_r <= in_ch.key;
    end
    if (commit) begin
      found_r  <= found_nxt;
      status_r <= status_nxt;
      entry_r  <= count_ext[4:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = found_r;
  assign out_ch.status      = status_r;
  assign out_ch.entry_count = entry_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= slt_pkg::CNT_W'(slt_pkg::DEPTH))
    else $error("key count above table depth");

  a_one_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slt_pkg::S_EXEC) |-> $onehot0(first_eq))
    else $error("more than one first match in the cell row");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && op_r == slt_pkg::OP_INSERT && full) |=> $stable(count_r))
    else $error("dropped insert changed the count");

  a_exec_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == slt_pkg::S_EXEC))
    else $error("accepted request did not enter the commit step");

  a_miss_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && op_r != slt_pkg::OP_INSERT && !hit) |=> $stable(count_r))
    else $error("count changed without a matching key");

endmodule
